### design/ihpc_pkg.sv
// shared types and constants for the ipv4 header parse and check block
// no dependencies; imported by every module of the block
package ihpc_pkg;

    localparam int unsigned COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MIN_HDR_LEN     = 16'd20;
    localparam logic [3:0]         IP_VERSION      = 4'd4;
    localparam logic [3:0]         MIN_IHL         = 4'd5;
    localparam logic [15:0]        SUM_ALL_ONES    = 16'hFFFF;
    localparam logic [15:0]        MAX_PAYLOAD_RST = 16'd65515;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_VERSION     = 3'd2,
        ST_IHL         = 3'd3,
        ST_TOTAL_LEN   = 3'd4,
        ST_CHECKSUM    = 3'd5,
        ST_PAYLOAD_LEN = 3'd6
    } t_status;

    // per-packet header state
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         first_byte;
        logic [7:0]         service_byte;
        logic [15:0]        length_word;
        logic [15:0]        ident_word;
        logic [15:0]        flags_offset_word;
        logic [15:0]        ttl_protocol_word;
        logic [31:0]        source_word;
        logic [31:0]        destination_word;
        logic [15:0]        ones_sum;
        logic [7:0]         pending_high_byte;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [3:0]  ihl;
        logic [5:0]  dscp;
        logic [1:0]  ecn;
        logic [15:0] tot_len;
        logic [15:0] identification;
        logic [2:0]  flags;
        logic [12:0] frag_offset;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } t_result;

endpackage

### design/ihpc_accum.sv
// packet state: byte counter, fixed header field capture and header checksum fold
// depends on ihpc_pkg
module ihpc_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_beat_en,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output ihpc_pkg::t_hdr o_hdr_next
);
    import ihpc_pkg::*;

    t_hdr               r_hdr;
    t_hdr               n_hdr;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] hlen_now;
    logic [16:0]        sum_raw;
    logic [16:0]        sum_fold;

    assign pos = r_hdr.byte_count;

    always_comb begin
        n_hdr = r_hdr;
        case (pos) inside
            16'd0:                 n_hdr.first_byte = i_byte;
            16'd1:                 n_hdr.service_byte = i_byte;
            16'd2, 16'd3:          n_hdr.length_word = {r_hdr.length_word[7:0], i_byte};
            16'd4, 16'd5:          n_hdr.ident_word = {r_hdr.ident_word[7:0], i_byte};
            16'd6, 16'd7:
                n_hdr.flags_offset_word = {r_hdr.flags_offset_word[7:0], i_byte};
            16'd8, 16'd9:
                n_hdr.ttl_protocol_word = {r_hdr.ttl_protocol_word[7:0], i_byte};
            [16'd12:16'd15]:       n_hdr.source_word = {r_hdr.source_word[23:0], i_byte};
            [16'd16:16'd19]:
                n_hdr.destination_word = {r_hdr.destination_word[23:0], i_byte};
            default: ;
        endcase

        // header length seen with byte 0 already in place
        hlen_now = {{(COUNT_W-6){1'b0}}, n_hdr.first_byte[3:0], 2'b00};
        sum_raw  = {1'b0, r_hdr.ones_sum} + {1'b0, r_hdr.pending_high_byte, i_byte};
        sum_fold = {1'b0, sum_raw[15:0]} + {16'd0, sum_raw[16]};
        if (pos < hlen_now) begin
            if (!pos[0]) begin
                n_hdr.pending_high_byte = i_byte;
            end else begin
                n_hdr.ones_sum = sum_fold[15:0];
            end
        end

        if (pos != COUNT_MAX) begin
            n_hdr.byte_count = pos + 16'd1;
        end
    end

    assign o_hdr_next = n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_beat_en) begin
            if (i_last) begin
                r_hdr <= '0;
            end else begin
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

### design/ihpc_check.sv
// end-of-packet checks in priority order and result field extraction
// depends on ihpc_pkg
module ihpc_check (
    input  ihpc_pkg::t_hdr    i_hdr,
    input  logic [15:0]       i_max_pay_len,
    output ihpc_pkg::t_result o_result
);
    import ihpc_pkg::*;

    logic [COUNT_W-1:0] len;
    logic [3:0]         ihl;
    logic [15:0]        hlen;
    logic [15:0]        tot;
    logic [15:0]        pay_len;
    t_status            status;

    assign len     = i_hdr.byte_count;
    assign ihl     = i_hdr.first_byte[3:0];
    assign hlen    = {10'd0, ihl, 2'b00};
    assign tot     = i_hdr.length_word;
    assign pay_len = tot - hlen;

    always_comb begin
        if (len < MIN_HDR_LEN) begin
            status = ST_SHORT;
        end else if (i_hdr.first_byte[7:4] != IP_VERSION) begin
            status = ST_VERSION;
        end else if (ihl < MIN_IHL || len < hlen) begin
            status = ST_IHL;
        end else if (tot < hlen || tot > len) begin
            status = ST_TOTAL_LEN;
        end else if (i_hdr.ones_sum != SUM_ALL_ONES) begin
            status = ST_CHECKSUM;
        end else if (pay_len > i_max_pay_len) begin
            status = ST_PAYLOAD_LEN;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.ihl                 = ihl;
            o_result.dscp                = i_hdr.service_byte[7:2];
            o_result.ecn                 = i_hdr.service_byte[1:0];
            o_result.tot_len             = tot;
            o_result.identification      = i_hdr.ident_word;
            o_result.flags               = i_hdr.flags_offset_word[15:13];
            o_result.frag_offset         = i_hdr.flags_offset_word[12:0];
            o_result.ttl                 = i_hdr.ttl_protocol_word[15:8];
            o_result.protocol            = i_hdr.ttl_protocol_word[7:0];
            o_result.source_address      = i_hdr.source_word;
            o_result.destination_address = i_hdr.destination_word;
        end
    end

endmodule

### design/ipv4_header_parse_check_core.sv
// Usage:
//   Packet bytes enter on the input channel (i_in_valid / o_in_ready), header
//   first, one byte per beat, with i_last_byte set on the final byte. Every
//   packet gives exactly one result beat on the output channel (o_out_valid /
//   i_out_ready): a status and the fixed header fields, which are zero unless
//   the status is ok. Option and payload bytes are counted, not kept.
//   Throughput is one byte per cycle, set by the per-byte update of the packet
//   state (field capture plus one 16-bit ones' complement add), while no last
//   byte is stalled. A last byte is checked from the input register and its
//   result is loaded into the output register once that register has room.
//   When the receiver stalls, non-last bytes keep flowing; a last byte waits
//   in the input register while the output register holds an unaccepted
//   result, and o_in_ready stays low until that result is taken.
//   The payload limit is written through i_cfg_wr_en / i_cfg_wr_data while the
//   block is idle. Reset (i_rst_n low, synchronous) clears the packet state,
//   empties both registers and sets the payload limit to 65515.
// depends on ihpc_pkg, ihpc_accum, ihpc_check
module ipv4_header_parse_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_ihl,
    output logic [5:0]  o_dscp,
    output logic [1:0]  o_ecn,
    output logic [15:0] o_tot_len,
    output logic [15:0] o_identification,
    output logic [2:0]  o_flags,
    output logic [12:0] o_frag_offset,
    output logic [7:0]  o_ttl,
    output logic [7:0]  o_protocol,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address
);
    import ihpc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_pay_len;
    logic        advance;
    t_hdr        hdr_next;
    t_result     result;

    // only a last beat needs room in the output register
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pay_len <= MAX_PAYLOAD_RST;
        end else if (i_cfg_wr_en) begin
            r_max_pay_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ihpc_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat_en  (advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_hdr_next (hdr_next)
    );

    ihpc_check u_check (
        .i_hdr         (hdr_next),
        .i_max_pay_len (r_max_pay_len),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out.status;
    assign o_ihl                 = r_out.ihl;
    assign o_dscp                = r_out.dscp;
    assign o_ecn                 = r_out.ecn;
    assign o_tot_len             = r_out.tot_len;
    assign o_identification      = r_out.identification;
    assign o_flags               = r_out.flags;
    assign o_frag_offset         = r_out.frag_offset;
    assign o_ttl                 = r_out.ttl;
    assign o_protocol            = r_out.protocol;
    assign o_source_address      = r_out.source_address;
    assign o_destination_address = r_out.destination_address;

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_ihl == 4'd0 && o_tot_len == 16'd0 && o_ttl == 8'd0 &&
            o_source_address == 32'd0 && o_destination_address == 32'd0)
        else $error("header fields not zero on error status");

    a_ok_ihl_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_ihl >= MIN_IHL &&
            o_tot_len >= {10'd0, o_ihl, 2'b00})
        else $error("ok status with inconsistent header length");

    a_ready_low_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_in_last && r_out_valid && !i_out_ready)
        else $error("input stalled without a blocked last beat");

    a_last_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !i_out_ready |=>
            r_in_valid && r_in_last && r_out_valid)
        else $error("stalled last beat or result dropped");
`endif

endmodule
